>>> rtl/core/u8sb_pkg.sv
// ----------------------------------------------------------------------------
// u8sb_pkg
// Shared types and codes of the UTF-8 to single-byte transcoder.
// ----------------------------------------------------------------------------
package u8sb_pkg;

	// Kind of multi-byte sequence in progress.
	localparam logic [1:0] KIND_NONE  = 2'd0;
	localparam logic [1:0] KIND_DROP  = 2'd1;
	localparam logic [1:0] KIND_THREE = 2'd2;
	localparam logic [1:0] KIND_TWO   = 2'd3;

	// Configuration register indexes.
	localparam logic REG_REPLACEMENT = 1'b0;
	localparam logic REG_BULLET      = 1'b1;

	localparam logic [7:0] REPLACEMENT_RESET = 8'h3F;
	localparam logic [7:0] BULLET_RESET      = 8'h95;

	// Lead byte thresholds and the bullet sequence.
	localparam logic [7:0] LEAD_FOUR  = 8'hF0;
	localparam logic [7:0] LEAD_THREE = 8'hE0;
	localparam logic [7:0] LEAD_TWO   = 8'hC0;
	localparam logic [7:0] BULLET_B0  = 8'hE2;
	localparam logic [7:0] BULLET_B1  = 8'h80;
	localparam logic [7:0] BULLET_B2  = 8'hA2;

	typedef struct packed {
		logic [1:0] kind;
		logic [1:0] bytes_left;
		logic [4:0] lead_bits;
		logic       bullet_match;
	} seq_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       byte_valid;
		logic       end_of_string;
		logic       bad_sequence;
	} res_t;

	localparam seq_t SEQ_IDLE = '{kind: KIND_NONE, bytes_left: 2'd0,
		lead_bits: 5'd0, bullet_match: 1'b0};

endpackage

>>> rtl/core/u8sb_decode.sv
// ----------------------------------------------------------------------------
// u8sb_decode
// Next sequence state and result for one byte, purely combinational.
// ----------------------------------------------------------------------------
module u8sb_decode (
	input  u8sb_pkg::seq_t seq,
	input  logic [7:0]     in_byte,
	input  logic           in_last,
	input  logic [7:0]     replacement_code,
	input  logic [7:0]     bullet_code,
	output u8sb_pkg::seq_t seq_next,
	output logic           has_result,
	output u8sb_pkg::res_t res
);

	logic [1:0] left_dec;
	logic       match_next;

	assign left_dec = seq.bytes_left - 2'd1;
	assign match_next = seq.bullet_match &&
		((seq.bytes_left == 2'd2) ? (in_byte == u8sb_pkg::BULLET_B1)
		                          : (in_byte == u8sb_pkg::BULLET_B2));

	always_comb begin
		seq_next   = seq;
		has_result = 1'b0;
		res        = '{out_byte: 8'd0, byte_valid: 1'b0,
			end_of_string: in_last, bad_sequence: 1'b0};
		case (seq.kind)
			u8sb_pkg::KIND_DROP: begin
				seq_next.bytes_left = left_dec;
				if (left_dec == 2'd0) begin
					seq_next = u8sb_pkg::SEQ_IDLE;
				end
				has_result = in_last;
			end
			u8sb_pkg::KIND_THREE: begin
				seq_next.bytes_left   = left_dec;
				seq_next.bullet_match = match_next;
				if (left_dec == 2'd0) begin
					has_result     = 1'b1;
					res.byte_valid = 1'b1;
					res.out_byte   = match_next ? bullet_code : replacement_code;
					seq_next       = u8sb_pkg::SEQ_IDLE;
				end else if (in_last) begin
					has_result     = 1'b1;
					res.byte_valid = 1'b1;
					res.out_byte   = replacement_code;
				end
			end
			u8sb_pkg::KIND_TWO: begin
				// The code point fits in a byte only when the top three lead bits are zero.
				has_result     = 1'b1;
				res.byte_valid = 1'b1;
				res.out_byte   = (seq.lead_bits[4:2] == 3'd0) ?
					{seq.lead_bits[1:0], in_byte[5:0]} : replacement_code;
				seq_next       = u8sb_pkg::SEQ_IDLE;
			end
			default: begin
				if (in_byte >= u8sb_pkg::LEAD_FOUR) begin
					has_result          = 1'b1;
					res.byte_valid      = 1'b1;
					res.out_byte        = replacement_code;
					seq_next.kind       = u8sb_pkg::KIND_DROP;
					seq_next.bytes_left = 2'd3;
				end else if (in_byte >= u8sb_pkg::LEAD_THREE) begin
					if (in_last) begin
						has_result     = 1'b1;
						res.byte_valid = 1'b1;
						res.out_byte   = replacement_code;
					end else begin
						seq_next.kind         = u8sb_pkg::KIND_THREE;
						seq_next.bytes_left   = 2'd2;
						seq_next.bullet_match = (in_byte == u8sb_pkg::BULLET_B0);
					end
				end else if (in_byte >= u8sb_pkg::LEAD_TWO) begin
					if (in_last) begin
						has_result       = 1'b1;
						res.bad_sequence = 1'b1;
					end else begin
						seq_next.kind       = u8sb_pkg::KIND_TWO;
						seq_next.bytes_left = 2'd1;
						seq_next.lead_bits  = in_byte[4:0];
					end
				end else begin
					has_result     = 1'b1;
					res.byte_valid = 1'b1;
					res.out_byte   = in_byte;
				end
			end
		endcase
		// A final byte always leaves the sequence state idle.
		if (in_last) begin
			seq_next = u8sb_pkg::SEQ_IDLE;
		end
	end

endmodule

>>> rtl/core/u8sb_out_stage.sv
// ----------------------------------------------------------------------------
// u8sb_out_stage
// One-deep result register that holds an item until the sink takes it.
// ----------------------------------------------------------------------------
module u8sb_out_stage (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           load,
	input  u8sb_pkg::res_t load_data,
	input  logic           take,
	output logic           can_load,
	output logic           out_valid,
	output u8sb_pkg::res_t out_data
);

	logic           valid_q;
	u8sb_pkg::res_t data_q;

	assign can_load  = !valid_q || take;
	assign out_valid = valid_q;
	assign out_data  = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (take) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= load_data;
		end
	end

endmodule

>>> rtl/core/utf8_to_single_byte_transcoder.sv
// ----------------------------------------------------------------------------
// utf8_to_single_byte_transcoder
// Converts a UTF-8 byte stream into single-byte codes, one result at most
// for each input byte.
//
//   Channel  Direction  Handshake          Payload
//   s_*      in         s_tvalid/s_tready  tdata=in_byte, tlast=in_last
//   m_*      out        m_tvalid/m_tready  tdata=out_byte, tlast=end_of_string,
//                                          tuser={bad_sequence, byte_valid}
//   cfg_*    in         cfg_we             cfg_index, cfg_data
//
// One item per cycle sustained while m_tready stays high. An accepted byte sits
// in the input register, where the sequence decoder forms its result and the
// next sequence state; the result goes to the output register. A stall on m_tready
// holds the input register only when it has a result to hand on, so bytes
// that give no result keep flowing. Reset clears both registers, the sequence
// state and the configuration registers to their defaults.
// ----------------------------------------------------------------------------
module utf8_to_single_byte_transcoder (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] in_byte
	input  logic       s_tlast,
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [7:0] out_byte
	output logic       m_tlast,
	output logic [1:0] m_tuser,   // [0] byte_valid, [1] bad_sequence
	input  logic       cfg_we,
	input  logic       cfg_index,
	input  logic [7:0] cfg_data
);

	logic           valid_s1;
	logic [7:0]     byte_s1;
	logic           last_s1;
	logic [7:0]     replacement_q;
	logic [7:0]     bullet_q;
	u8sb_pkg::seq_t seq_q;
	u8sb_pkg::seq_t seq_next;
	u8sb_pkg::res_t res;
	u8sb_pkg::res_t out_data;
	logic           has_result;
	logic           can_load;
	logic           s1_adv;

	assign s1_adv   = valid_s1 && (!has_result || can_load);
	assign s_tready = !valid_s1 || s1_adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			replacement_q <= u8sb_pkg::REPLACEMENT_RESET;
			bullet_q      <= u8sb_pkg::BULLET_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				u8sb_pkg::REG_REPLACEMENT: replacement_q <= cfg_data;
				u8sb_pkg::REG_BULLET:      bullet_q      <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q <= u8sb_pkg::SEQ_IDLE;
		end else if (s1_adv) begin
			seq_q <= seq_next;
		end
	end

	u8sb_decode u_decode (
		.seq              (seq_q),
		.in_byte          (byte_s1),
		.in_last          (last_s1),
		.replacement_code (replacement_q),
		.bullet_code      (bullet_q),
		.seq_next         (seq_next),
		.has_result       (has_result),
		.res              (res)
	);

	u8sb_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (s1_adv && has_result),
		.load_data (res),
		.take      (m_tready),
		.can_load  (can_load),
		.out_valid (m_tvalid),
		.out_data  (out_data)
	);

	assign m_tdata    = out_data.out_byte;
	assign m_tlast    = out_data.end_of_string;
	assign m_tuser[0] = out_data.byte_valid;
	assign m_tuser[1] = out_data.bad_sequence;

	// An error result marks the end of the string and carries no character.
	a_bad_is_final: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[1] |-> m_tlast && !m_tuser[0])
		else $error("bad_sequence result without end of string or with a character");

	// A result without a character carries a zero code.
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> m_tdata == 8'd0)
		else $error("nonzero code on a result without a character");

	// The decoder never leaves a sequence pending after a final byte.
	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		s1_adv && last_s1 |=> seq_q.kind == u8sb_pkg::KIND_NONE)
		else $error("sequence state not idle after final byte");

	// Back pressure on the input only comes from a held byte.
	a_ready_reason: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> valid_s1 && has_result && m_tvalid && !m_tready)
		else $error("input stalled without a blocked result");

endmodule

>>> sim/utf8_transcode_checker.sv
// ----------------------------------------------------------------------------
// utf8_transcode_checker
// Watches the byte, result and register ports of the UTF-8 to single-byte
// transcoder. It decodes every accepted byte with its own copy of the sequence
// state and registers, queues the codes it expects, and compares each result
// that leaves the block, field by field, against the oldest queued code.
// ----------------------------------------------------------------------------
module utf8_transcode_checker (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	input  logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] in_byte
	input  logic       s_tlast,
	input  logic       m_tvalid,
	input  logic       m_tready,
	input  logic [7:0] m_tdata,   // [7:0] out_byte
	input  logic       m_tlast,
	input  logic [1:0] m_tuser,   // [0] byte_valid, [1] bad_sequence
	input  logic       cfg_we,
	input  logic       cfg_index,
	input  logic [7:0] cfg_data,
	output int         fail_count,
	output int         pending_count,
	output int         result_count
);
	timeunit 1ns;
	timeprecision 1ps;

	u8sb_pkg::seq_t decode_state;
	logic [7:0]     replacement_q;
	logic [7:0]     bullet_q;
	u8sb_pkg::res_t expected_codes[$];
	int             mismatch_count = 0;
	int             expected_left = 0;
	int             checked_count = 0;

	assign fail_count    = mismatch_count;
	assign pending_count = expected_left;
	assign result_count  = checked_count;

	task automatic report_mismatch(input string what, input int exp_v, input int got_v);
		if (mismatch_count < 40) begin
			$display("%0t ns: result %0d: %s: expected %0h, got %0h",
				$time, checked_count, what, exp_v, got_v);
		end
		mismatch_count++;
	endtask

	function automatic u8sb_pkg::res_t make_code(input logic [7:0] code, input logic valid,
		input logic last, input logic bad);
		u8sb_pkg::res_t r;
		r.out_byte      = valid ? code : 8'h00;
		r.byte_valid    = valid;
		r.end_of_string = last;
		r.bad_sequence  = bad;
		return r;
	endfunction

	// Decodes one byte against the current sequence state; returns 1 when the
	// byte produces a result.
	function automatic bit transcode_byte(input logic [7:0] b, input logic last,
		output u8sb_pkg::res_t r);
		bit          has;
		logic [10:0] joined_value;
		has = 1'b0;
		r = '0;
		case (decode_state.kind)
			u8sb_pkg::KIND_DROP: begin
				decode_state.bytes_left = decode_state.bytes_left - 2'd1;
				if (decode_state.bytes_left == 2'd0)
					decode_state = u8sb_pkg::SEQ_IDLE;
				if (last) begin
					r = make_code(8'h00, 1'b0, 1'b1, 1'b0);
					has = 1'b1;
				end
			end
			u8sb_pkg::KIND_THREE: begin
				if (decode_state.bytes_left == 2'd2)
					decode_state.bullet_match = decode_state.bullet_match
						&& (b == u8sb_pkg::BULLET_B1);
				else
					decode_state.bullet_match = decode_state.bullet_match
						&& (b == u8sb_pkg::BULLET_B2);
				decode_state.bytes_left = decode_state.bytes_left - 2'd1;
				if (decode_state.bytes_left == 2'd0) begin
					r = make_code(decode_state.bullet_match ? bullet_q : replacement_q,
						1'b1, last, 1'b0);
					has = 1'b1;
					decode_state = u8sb_pkg::SEQ_IDLE;
				end else if (last) begin
					// The string ended before the third byte arrived.
					r = make_code(replacement_q, 1'b1, 1'b1, 1'b0);
					has = 1'b1;
				end
			end
			u8sb_pkg::KIND_TWO: begin
				joined_value = {decode_state.lead_bits, b[5:0]};
				r = make_code((joined_value <= 11'd255) ? joined_value[7:0] : replacement_q,
					1'b1, last, 1'b0);
				has = 1'b1;
				decode_state = u8sb_pkg::SEQ_IDLE;
			end
			default: begin
				if (b >= u8sb_pkg::LEAD_FOUR) begin
					r = make_code(replacement_q, 1'b1, last, 1'b0);
					has = 1'b1;
					decode_state.kind = u8sb_pkg::KIND_DROP;
					decode_state.bytes_left = 2'd3;
				end else if (b >= u8sb_pkg::LEAD_THREE) begin
					if (last) begin
						r = make_code(replacement_q, 1'b1, 1'b1, 1'b0);
						has = 1'b1;
					end else begin
						decode_state.kind = u8sb_pkg::KIND_THREE;
						decode_state.bytes_left = 2'd2;
						decode_state.bullet_match = (b == u8sb_pkg::BULLET_B0);
					end
				end else if (b >= u8sb_pkg::LEAD_TWO) begin
					if (last) begin
						r = make_code(8'h00, 1'b0, 1'b1, 1'b1);
						has = 1'b1;
					end else begin
						decode_state.kind = u8sb_pkg::KIND_TWO;
						decode_state.bytes_left = 2'd1;
						decode_state.lead_bits = b[4:0];
					end
				end else begin
					r = make_code(b, 1'b1, last, 1'b0);
					has = 1'b1;
				end
			end
		endcase
		// A final byte always leaves the decoder idle for the next string.
		if (last)
			decode_state = u8sb_pkg::SEQ_IDLE;
		return has;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		u8sb_pkg::res_t want;
		u8sb_pkg::res_t got;
		if (!arst_n) begin
			decode_state  = u8sb_pkg::SEQ_IDLE;
			replacement_q = u8sb_pkg::REPLACEMENT_RESET;
			bullet_q      = u8sb_pkg::BULLET_RESET;
			expected_codes.delete();
			expected_left = 0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == u8sb_pkg::REG_REPLACEMENT)
					replacement_q = cfg_data;
				else
					bullet_q = cfg_data;
			end
			// A result cannot come from a byte accepted at the same edge.
			if (m_tvalid && m_tready) begin
				got.out_byte      = m_tdata;
				got.byte_valid    = m_tuser[0];
				got.end_of_string = m_tlast;
				got.bad_sequence  = m_tuser[1];
				if (expected_codes.size() == 0) begin
					report_mismatch("result with nothing expected, out_byte", 0, got.out_byte);
				end else begin
					want = expected_codes.pop_front();
					if (got.out_byte !== want.out_byte)
						report_mismatch("out_byte", want.out_byte, got.out_byte);
					if (got.byte_valid !== want.byte_valid)
						report_mismatch("byte_valid", want.byte_valid, got.byte_valid);
					if (got.end_of_string !== want.end_of_string)
						report_mismatch("end_of_string", want.end_of_string, got.end_of_string);
					if (got.bad_sequence !== want.bad_sequence)
						report_mismatch("bad_sequence", want.bad_sequence, got.bad_sequence);
				end
				checked_count++;
			end
			if (s_tvalid && s_tready) begin
				if (transcode_byte(s_tdata, s_tlast, want))
					expected_codes.push_back(want);
			end
			expected_left = expected_codes.size();
		end
	end

endmodule

>>> sim/utf8_to_single_byte_transcoder_tb.sv
// ----------------------------------------------------------------------------
// utf8_to_single_byte_transcoder_tb
// Drives UTF-8 strings into the transcoder and gives the verdict. A directed
// set of sequences comes first, then random strings built mostly from
// well-formed characters, with truncation and noise, under several register
// settings and idling patterns, including one long output hold-off.
// ----------------------------------------------------------------------------
module utf8_to_single_byte_transcoder_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int PHASE_BYTES   = 170;
	localparam int HOLD_CYCLES   = 300;
	localparam int DRAIN_CYCLES  = 8;
	localparam int STALL_LIMIT   = 2000;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       s_tvalid = 1'b0;
	logic       s_tready;
	logic [7:0] s_tdata = 8'h00;
	logic       s_tlast = 1'b0;
	logic       m_tvalid;
	logic       m_tready = 1'b0;
	logic [7:0] m_tdata;
	logic       m_tlast;
	logic [1:0] m_tuser;
	logic       cfg_we = 1'b0;
	logic       cfg_index = u8sb_pkg::REG_REPLACEMENT;
	logic [7:0] cfg_data = 8'h00;

	int fail_count;
	int pending_count;
	int result_count;

	int tx_max_gap = 3;
	int rx_max_gap = 3;
	bit hold_request = 1'b0;
	int sent_bytes = 0;
	int sent_strings = 0;
	int reg_writes = 0;
	int quiet_cycles = 0;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	utf8_to_single_byte_transcoder i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.m_tuser   (m_tuser),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	utf8_transcode_checker i_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_tvalid      (s_tvalid),
		.s_tready      (s_tready),
		.s_tdata       (s_tdata),
		.s_tlast       (s_tlast),
		.m_tvalid      (m_tvalid),
		.m_tready      (m_tready),
		.m_tdata       (m_tdata),
		.m_tlast       (m_tlast),
		.m_tuser       (m_tuser),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.fail_count    (fail_count),
		.pending_count (pending_count),
		.result_count  (result_count)
	);

	// The run ends if no item moves on either channel for too long.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
			$display("Watchdog: no item moved for %0d cycles.", STALL_LIMIT);
			$display("TEST FAILED");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Result side: a random wait before each item, and one long hold-off when
	// the stimulus asks for it.
	initial begin
		int gap;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			if (hold_request) begin
				m_tready = 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_request = 1'b0;
			end
			gap = $urandom_range(rx_max_gap);
			if (gap > 0) begin
				m_tready = 1'b0;
				repeat (gap) @(negedge clk);
			end
			m_tready = 1'b1;
			do @(posedge clk); while (!(m_tvalid && m_tready));
			@(negedge clk);
		end
	end

	task automatic send_byte(input logic [7:0] b, input logic last);
		int gap;
		gap = $urandom_range(tx_max_gap);
		if (gap > 0) begin
			s_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tdata  = b;
		s_tlast  = last;
		s_tvalid = 1'b1;
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
		sent_bytes++;
		if (last)
			sent_strings++;
	endtask

	task automatic write_reg(input logic idx, input logic [7:0] value);
		cfg_we    = 1'b1;
		cfg_index = idx;
		cfg_data  = value;
		@(negedge clk);
		cfg_we = 1'b0;
		reg_writes++;
	endtask

	// Waits until every expected code has arrived and the pipeline is empty.
	task automatic wait_drained();
		s_tvalid = 1'b0;
		while (pending_count != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic send_random_string();
		logic [7:0] str_bytes[$];
		int n_chars;
		int pick;
		int cut;
		n_chars = ($urandom_range(9) == 0) ? 40 : $urandom_range(12, 1);
		for (int c = 0; c < n_chars; c++) begin
			pick = $urandom_range(99);
			if (pick < 25) begin
				str_bytes.push_back(8'($urandom_range(8'h7F)));
			end else if (pick < 32) begin
				// Stray continuation byte.
				str_bytes.push_back(8'($urandom_range(8'hBF, 8'h80)));
			end else if (pick < 52) begin
				// At least half of the two-byte leads fall in the range that fits a byte.
				str_bytes.push_back(8'($urandom_range(1) ? $urandom_range(8'hC3, 8'hC0)
					: $urandom_range(8'hDF, 8'hC0)));
				str_bytes.push_back(8'(($urandom_range(3) == 0) ? $urandom_range(8'hFF)
					: $urandom_range(8'hBF, 8'h80)));
			end else if (pick < 72) begin
				// The bullet, now and then with one or more bytes altered.
				str_bytes.push_back(8'(($urandom_range(5) == 0)
					? $urandom_range(8'hEF, 8'hE0) : u8sb_pkg::BULLET_B0));
				str_bytes.push_back(8'(($urandom_range(5) == 0)
					? $urandom_range(8'hFF) : u8sb_pkg::BULLET_B1));
				str_bytes.push_back(8'(($urandom_range(5) == 0)
					? $urandom_range(8'hFF) : u8sb_pkg::BULLET_B2));
			end else if (pick < 85) begin
				str_bytes.push_back(8'($urandom_range(8'hEF, 8'hE0)));
				str_bytes.push_back(8'($urandom_range(8'hFF)));
				str_bytes.push_back(8'($urandom_range(8'hFF)));
			end else if (pick < 95) begin
				str_bytes.push_back(8'($urandom_range(8'hFF, 8'hF0)));
				repeat (3) str_bytes.push_back(8'($urandom_range(8'hFF)));
			end else begin
				str_bytes.push_back(8'($urandom_range(8'hFF)));
			end
		end
		// Cut some strings short so they may end inside a sequence.
		if ($urandom_range(3) == 0) begin
			cut = $urandom_range(str_bytes.size(), 1);
			while (str_bytes.size() > cut)
				void'(str_bytes.pop_back());
		end
		for (int i = 0; i < str_bytes.size(); i++)
			send_byte(str_bytes[i], i == str_bytes.size() - 1);
	endtask

	initial begin
		int phase_start;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed sequences under the reset register values.
		send_byte(8'h00, 1'b0);
		send_byte(8'hBF, 1'b0);
		send_byte(8'hC3, 1'b0);
		send_byte(8'hA9, 1'b0);
		send_byte(8'hC4, 1'b0);
		send_byte(8'h80, 1'b0);
		send_byte(8'hE2, 1'b0);
		send_byte(8'h80, 1'b0);
		send_byte(8'hA2, 1'b0);
		send_byte(8'hE2, 1'b0);
		send_byte(8'h80, 1'b0);
		send_byte(8'hA3, 1'b0);
		send_byte(8'hE0, 1'b0);
		send_byte(8'h80, 1'b1);   // three-byte sequence cut short
		send_byte(8'hF0, 1'b0);
		send_byte(8'h90, 1'b0);
		send_byte(8'h80, 1'b0);
		send_byte(8'h80, 1'b0);
		send_byte(8'hF4, 1'b0);
		send_byte(8'h00, 1'b1);   // dropped tail byte ends the string
		send_byte(8'hC5, 1'b1);   // two-byte lead ends the string
		send_byte(8'hFF, 1'b1);
		send_byte(8'hE5, 1'b1);
		send_byte(8'h7F, 1'b1);
		wait_drained();

		for (int phase = 0; phase < 6; phase++) begin
			case (phase)
				0: begin
					tx_max_gap = 6; rx_max_gap = 6;
					write_reg(u8sb_pkg::REG_REPLACEMENT, 8'h00);
					write_reg(u8sb_pkg::REG_BULLET, 8'hFF);
				end
				1: begin
					tx_max_gap = 0; rx_max_gap = 0;
					write_reg(u8sb_pkg::REG_REPLACEMENT, 8'hFF);
					write_reg(u8sb_pkg::REG_BULLET, 8'h00);
				end
				2: begin
					tx_max_gap = 6; rx_max_gap = 0;
					write_reg(u8sb_pkg::REG_REPLACEMENT, 8'($urandom_range(8'hFF)));
				end
				3: begin
					tx_max_gap = 0; rx_max_gap = 6;
					write_reg(u8sb_pkg::REG_BULLET, 8'($urandom_range(8'hFF)));
					hold_request = 1'b1;
				end
				4: begin
					tx_max_gap = 3; rx_max_gap = 6;
					write_reg(u8sb_pkg::REG_REPLACEMENT, 8'($urandom_range(8'hFF)));
					write_reg(u8sb_pkg::REG_BULLET, 8'($urandom_range(8'hFF)));
				end
				default: begin
					tx_max_gap = 6; rx_max_gap = 3;
					write_reg(u8sb_pkg::REG_REPLACEMENT, u8sb_pkg::REPLACEMENT_RESET);
					write_reg(u8sb_pkg::REG_BULLET, u8sb_pkg::BULLET_RESET);
				end
			endcase
			phase_start = sent_bytes;
			while (sent_bytes - phase_start < PHASE_BYTES)
				send_random_string();
			wait_drained();
		end

		$display("Sent %0d bytes in %0d strings; %0d results checked.",
			sent_bytes, sent_strings, result_count);
		$display("Made %0d register writes over six settings and one %0d-cycle output hold-off.",
			reg_writes, HOLD_CYCLES);
		if (fail_count == 0 && pending_count == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("%0d mismatches, %0d results still expected.", fail_count, pending_count);
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
